// ----- hw/rtl/dfhe_pkg.sv -----
// Shared types, code tables and constants of the fixed-Huffman DEFLATE encoder.
package dfhe_pkg;

	typedef enum logic [1:0] {
		CMD_HEADER  = 2'd0,
		CMD_LITERAL = 2'd1,
		CMD_MATCH   = 2'd2,
		CMD_EOB     = 2'd3
	} cmd_e;

	typedef struct packed {
		cmd_e        cmd;
		logic        final_flag;
		logic [7:0]  literal_byte;
		logic [8:0]  match_length;
		logic [15:0] match_distance;
	} tok_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       stream_done;
	} strm_t;

	localparam int ACC_W     = 38;
	localparam int CNT_W     = 6;
	localparam int BITS_W    = 31;
	localparam int IDX_W     = 5;

	// Bits of one token, oldest in bit 0, as they enter the bit packer.
	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic [CNT_W-1:0]  nbits;
		logic              flush;
	} code_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int LEN_CODES  = 29;
	localparam int DIST_CODES = 30;

	localparam logic [8:0]  MIN_MATCH    = 9'd3;
	localparam logic [8:0]  LONGEST_LEN  = 9'd258;
	localparam logic [15:0] MIN_DIST     = 16'd1;
	localparam logic [15:0] MAX_DIST     = 16'd32768;
	localparam logic [7:0]  LIT_SPLIT    = 8'd144;
	localparam logic [4:0]  LEN_SEVEN_HI = 5'd22;
	localparam logic [CNT_W-1:0] HDR_BITS = 6'd3;
	localparam logic [CNT_W-1:0] EOB_BITS = 6'd7;

	localparam logic [8:0] LEN_BASE [LEN_CODES] = '{
		9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13,
		9'd15, 9'd17, 9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59,
		9'd67, 9'd83, 9'd99, 9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};

	localparam logic [2:0] LEN_EXTRA [LEN_CODES] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
		3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd0};

	localparam logic [15:0] DIST_BASE [DIST_CODES] = '{
		16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
		16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385,
		16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097,
		16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577};

	localparam logic [3:0] DIST_EXTRA [DIST_CODES] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
		4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8,
		4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

endpackage

// ----- hw/rtl/dfhe_front.sv -----
// Token front end: clamps and classifies tokens, then builds their bit strings.
module dfhe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tok_valid,
	output logic                  tok_stall,
	input  dfhe_pkg::tok_t        tok,
	input  logic [dfhe_pkg::QCNT_W-1:0] q_count,
	output logic                  push,
	output dfhe_pkg::code_t       code
);
	import dfhe_pkg::*;

	logic        accept;
	logic        final_q;
	logic [8:0]  len_c;
	logic [15:0] dist_c;
	logic [IDX_W-1:0] len_idx;
	logic [IDX_W-1:0] dist_idx;

	logic             valid_s1;
	cmd_e             cmd_s1;
	logic             ff_s1;
	logic             flush_s1;
	logic [7:0]       lit_s1;
	logic [IDX_W-1:0] len_idx_s1;
	logic [4:0]       len_xv_s1;
	logic [IDX_W-1:0] dist_idx_s1;
	logic [12:0]      dist_xv_s1;

	logic [8:0]       lit_code;
	logic [3:0]       lit_n;
	logic [8:0]       len_code;
	logic [3:0]       len_n;
	logic [8:0]       len_rev;
	logic [4:0]       dist_rev;
	logic [2:0]       len_ne;
	logic [3:0]       dist_ne;
	logic [CNT_W-1:0] sh_xl;
	logic [CNT_W-1:0] sh_dc;
	logic [CNT_W-1:0] sh_xd;

	// Reverses the low n bits of a code so that its leading bit goes out first.
	function automatic logic [8:0] rev_code(input logic [8:0] c, input logic [3:0] n);
		logic [8:0] r;
		for (int i = 0; i < 9; i++) begin
			r[i] = c[8-i];
		end
		return r >> (4'd9 - n);
	endfunction

	// Keep room in the queue for the token held here and one more.
	assign tok_stall = ({1'b0, q_count} + {{QCNT_W{1'b0}}, valid_s1})
		>= (QCNT_W+1)'(QUEUE_DEPTH);
	assign accept = tok_valid && !tok_stall;

	always_comb begin
		if (tok.match_length < MIN_MATCH) begin
			len_c = MIN_MATCH;
		end else if (tok.match_length > LONGEST_LEN) begin
			len_c = LONGEST_LEN;
		end else begin
			len_c = tok.match_length;
		end
		if (tok.match_distance < MIN_DIST) begin
			dist_c = MIN_DIST;
		end else if (tok.match_distance > MAX_DIST) begin
			dist_c = MAX_DIST;
		end else begin
			dist_c = tok.match_distance;
		end
		len_idx = '0;
		for (int i = 1; i < LEN_CODES; i++) begin
			if (LEN_BASE[i] <= len_c) begin
				len_idx = IDX_W'(i);
			end
		end
		dist_idx = '0;
		for (int i = 1; i < DIST_CODES; i++) begin
			if (DIST_BASE[i] <= dist_c) begin
				dist_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			final_q  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept && tok.cmd == CMD_HEADER) begin
				final_q <= tok.final_flag;
			end else if (accept && tok.cmd == CMD_EOB) begin
				final_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= tok.cmd;
			ff_s1       <= tok.final_flag;
			flush_s1    <= (tok.cmd == CMD_EOB) && final_q;
			lit_s1      <= tok.literal_byte;
			len_idx_s1  <= len_idx;
			len_xv_s1   <= 5'(len_c - LEN_BASE[len_idx]);
			dist_idx_s1 <= dist_idx;
			dist_xv_s1  <= 13'(dist_c - DIST_BASE[dist_idx]);
		end
	end

	always_comb begin
		if (lit_s1 < LIT_SPLIT) begin
			lit_code = 9'h030 + {1'b0, lit_s1};
			lit_n    = 4'd8;
		end else begin
			lit_code = 9'h190 + {1'b0, lit_s1 - LIT_SPLIT};
			lit_n    = 4'd9;
		end
		if (len_idx_s1 <= LEN_SEVEN_HI) begin
			len_code = {4'd0, len_idx_s1} + 9'd1;
			len_n    = 4'd7;
		end else begin
			len_code = 9'h0C0 + {4'd0, len_idx_s1 - (LEN_SEVEN_HI + 5'd1)};
			len_n    = 4'd8;
		end
		len_rev  = rev_code(len_code, len_n);
		dist_rev = {dist_idx_s1[0], dist_idx_s1[1], dist_idx_s1[2], dist_idx_s1[3],
			dist_idx_s1[4]};
		len_ne   = LEN_EXTRA[len_idx_s1];
		dist_ne  = DIST_EXTRA[dist_idx_s1];
		sh_xl    = CNT_W'(len_n);
		sh_dc    = sh_xl + CNT_W'(len_ne);
		sh_xd    = sh_dc + CNT_W'(5);

		code.flush = flush_s1;
		unique case (cmd_s1)
			CMD_HEADER: begin
				code.bits  = BITS_W'({2'b01, ff_s1});
				code.nbits = HDR_BITS;
			end
			CMD_LITERAL: begin
				code.bits  = BITS_W'(rev_code(lit_code, lit_n));
				code.nbits = CNT_W'(lit_n);
			end
			CMD_MATCH: begin
				code.bits  = BITS_W'(len_rev)
					| (BITS_W'(len_xv_s1) << sh_xl)
					| (BITS_W'(dist_rev) << sh_dc)
					| (BITS_W'(dist_xv_s1) << sh_xd);
				code.nbits = sh_xd + CNT_W'(dist_ne);
			end
			CMD_EOB: begin
				code.bits  = '0;
				code.nbits = EOB_BITS;
			end
			default: begin
				code.bits  = '0;
				code.nbits = '0;
			end
		endcase
	end

	assign push = valid_s1;

endmodule

// ----- hw/rtl/dfhe_queue.sv -----
// Short queue of token bit strings between the front end and the bit packer.
module dfhe_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  dfhe_pkg::code_t             wdata,
	input  logic                        pop,
	output logic                        nonempty,
	output dfhe_pkg::code_t             rdata,
	output logic [dfhe_pkg::QCNT_W-1:0] count
);
	import dfhe_pkg::*;

	code_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign do_pop   = pop && (count_q != '0);
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !do_pop && count_q == QCNT_W'(QUEUE_DEPTH)))
		else $error("queue written while full");

endmodule

// ----- hw/rtl/dfhe_packer.sv -----
// Bit packer: appends bit strings to the accumulator; one byte a cycle unless stalled.
module dfhe_packer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  dfhe_pkg::code_t q_data,
	output logic            pop,
	output logic            strm_valid,
	input  logic            strm_stall,
	output dfhe_pkg::strm_t strm
);
	import dfhe_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             flush_q;
	logic             out_valid_q;
	strm_t            out_q;

	logic             out_ok;
	logic             emit;
	logic             last;
	logic             flush_after;
	logic [ACC_W-1:0] acc_after;
	logic [CNT_W-1:0] cnt_after;

	assign out_ok = !out_valid_q || !strm_stall;
	assign emit   = out_ok && ((cnt_q >= CNT_W'(8)) || (flush_q && cnt_q != '0));

	always_comb begin
		if (emit) begin
			acc_after = acc_q >> 8;
			cnt_after = (cnt_q >= CNT_W'(8)) ? cnt_q - CNT_W'(8) : '0;
		end else begin
			acc_after = acc_q;
			cnt_after = cnt_q;
		end
		// A byte is the last of its token once fewer than eight bits remain,
		// or once nothing remains while a final block is being flushed.
		last        = emit && (flush_q ? (cnt_after == '0) : (cnt_after < CNT_W'(8)));
		flush_after = flush_q && (cnt_after != '0);
		pop         = q_nonempty && (cnt_after < CNT_W'(8)) && !flush_after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q   <= acc_after | (ACC_W'(q_data.bits) << cnt_after);
				cnt_q   <= cnt_after + q_data.nbits;
				flush_q <= q_data.flush;
			end else begin
				acc_q   <= acc_after;
				cnt_q   <= cnt_after;
				flush_q <= flush_after;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!strm_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte    <= acc_q[7:0];
			out_q.last_of_run <= last;
			out_q.stream_done <= last && flush_q;
		end
	end

	assign strm_valid = out_valid_q;
	assign strm       = out_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ACC_W))
		else $error("bit count beyond accumulator width");

	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q >> cnt_q) == '0)
		else $error("stray bits above the bit count");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> cnt_q != '0)
		else $error("flush pending with an empty accumulator");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && last && flush_q |=> strm_valid && strm.stream_done && strm.last_of_run)
		else $error("stream end byte not marked as last");

endmodule

// ----- hw/rtl/deflate_fixed_huffman_encoder_unit.sv -----
// Fixed-Huffman DEFLATE encoder top level: front end, token queue and bit packer.
// Takes parsed LZ77 tokens (block header, literal, match, end of block) and emits the
// fixed-Huffman stream one byte per transaction, least significant bit first. The
// front end accepts a token every cycle while its four-entry queue has room; the
// bit packer takes the next token once fewer than eight bits of the last remain,
// so bytes of one token can still wait to leave as the next comes in. The byte
// output register is the limit: one byte leaves per cycle while strm_stall is low.
// A token passes the front-end register, the queue, the accumulator and the byte
// output register. An end of block in a final block pads the last byte with zeros,
// marks it stream_done, and the next token starts afresh.
module deflate_fixed_huffman_encoder_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_valid,
	output logic            tok_stall,
	input  dfhe_pkg::tok_t  tok,
	output logic            strm_valid,
	input  logic            strm_stall,
	output dfhe_pkg::strm_t strm
);
	import dfhe_pkg::*;

	logic              push;
	code_t             wcode;
	logic              pop;
	logic              q_nonempty;
	code_t             rcode;
	logic [QCNT_W-1:0] q_count;

	dfhe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok),
		.q_count   (q_count),
		.push      (push),
		.code      (wcode)
	);

	dfhe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (wcode),
		.pop      (pop),
		.nonempty (q_nonempty),
		.rdata    (rcode),
		.count    (q_count)
	);

	dfhe_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (rcode),
		.pop        (pop),
		.strm_valid (strm_valid),
		.strm_stall (strm_stall),
		.strm       (strm)
	);

endmodule
